@@ src/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HKRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HKRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/hkrb_pkg.sv @@
// Package for the HID key report builder: beat types, codes, defaults.
// No dependencies.
`default_nettype none

package hkrb_pkg;

    localparam int SLOT_COUNT_DEF   = 6;
    localparam int BITMAP_BYTES_DEF = 16;

    localparam int         BYTE_SHIFT = 3;
    localparam logic [2:0] BIT_MASK   = 3'd7;
    localparam logic [7:0] MOD_FIRST  = 8'hE0;
    localparam logic [7:0] MOD_LAST   = 8'hE7;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_DEL   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] key_code;
    } t_in;

    typedef struct packed {
        logic       key_present;
        logic       any_key;
        logic [7:0] modifier_bits;
        logic       dropped;
    } t_out;

endpackage

`default_nettype wire

@@ src/hid_key_report_builder_unit.sv @@
// A request walks the active store in slot or bitmap mode, and both stores for a clear,
// then finishes; busy drops with o_done, so a new item is taken only after the last one
// is done. The walk is set by the index counter that steps through the stores.
// Results are one-cycle strobed beats; the receiver cannot stall.
// Reset (sync, active low) empties slots, bitmap and modifiers, selects bitmap mode.
// Depends on hkrb_pkg.
`default_nettype none

module hid_key_report_builder_unit #(
    parameter int SLOT_COUNT   = hkrb_pkg::SLOT_COUNT_DEF,   // 1..16
    parameter int BITMAP_BYTES = hkrb_pkg::BITMAP_BYTES_DEF  // 1..32
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  hkrb_pkg::t_in   i_item,
    input  wire             i_cfg_we,
    input  wire             i_cfg_wdata,
    output logic            o_done,
    output hkrb_pkg::t_out  o_result
);

    import hkrb_pkg::*;

    // Index widths. The scan counter covers whichever store is larger.
    localparam int SCAN_N = (SLOT_COUNT > BITMAP_BYTES) ? SLOT_COUNT : BITMAP_BYTES;
    localparam int SCAN_W = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BM_W   = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

    localparam logic [7:0]        SLOT_N8  = 8'(SLOT_COUNT);
    localparam logic [7:0]        BM_N8    = 8'(BITMAP_BYTES);
    localparam logic [SCAN_W-1:0] LAST_ALL = SCAN_W'(SCAN_N - 1);
    localparam logic [SCAN_W-1:0] LAST_SL  = SCAN_W'(SLOT_COUNT - 1);
    localparam logic [SCAN_W-1:0] LAST_BM  = SCAN_W'(BITMAP_BYTES - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [SCAN_W-1:0] r_idx, n_idx;
    t_action           r_act, n_act;
    logic [7:0]        r_code, n_code;
    logic              r_found, n_found;        // code seen in a slot (still held)
    logic              r_freed, n_freed;        // delete already cleared one slot
    logic              r_free_vld, n_free_vld;  // first empty slot located
    logic [SLOT_W-1:0] r_free_idx, n_free_idx;
    logic              r_any, n_any;            // OR of the active store after update
    logic              r_pres_bm, n_pres_bm;    // key bit after update, bitmap mode
    logic              r_mode;                  // 1 = bitmap report
    logic [7:0]        r_mod, n_mod;
    logic              r_done, n_done;
    t_out              r_result, n_result;

    logic [7:0] r_slots  [SLOT_COUNT];
    logic [7:0] r_bitmap [BITMAP_BYTES];

    // Single write port per store, driven by the sequencer.
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [7:0]        slot_wdata;
    logic              bm_we;
    logic [BM_W-1:0]   bm_waddr;
    logic [7:0]        bm_wdata;

    // ------------------------------------------------------------------
    // Decode of the latched key code
    // ------------------------------------------------------------------
    logic       c_zero, c_mod, c_key, c_in_bm;
    logic [4:0] c_byte;
    logic [2:0] c_bit;

    always_comb begin
        c_zero  = (r_code == 8'd0);
        c_mod   = r_code inside {[MOD_FIRST:MOD_LAST]};
        c_key   = !c_zero && !c_mod;
        c_byte  = 5'(r_code >> BYTE_SHIFT);
        c_bit   = r_code[2:0] & BIT_MASK;
        c_in_bm = ({3'b000, c_byte} < BM_N8);
    end

    // ------------------------------------------------------------------
    // Sequencer and shared compare/update step
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] s_i;
    logic [BM_W-1:0]   b_i;
    logic              s_lane, b_lane;
    logic [7:0]        s_val, s_post, b_val, b_post;
    logic              s_hit;
    logic [SCAN_W-1:0] last_idx;
    logic              wrote;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_act      = r_act;
        n_code     = r_code;
        n_found    = r_found;
        n_freed    = r_freed;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_any      = r_any;
        n_pres_bm  = r_pres_bm;
        n_mod      = r_mod;
        n_done     = 1'b0;
        n_result   = r_result;

        s_i    = r_idx[SLOT_W-1:0];
        b_i    = r_idx[BM_W-1:0];

        slot_we    = 1'b0;
        slot_waddr = s_i;
        slot_wdata = 8'd0;
        bm_we      = 1'b0;
        bm_waddr   = b_i;
        bm_wdata   = 8'd0;

        s_lane = (8'(r_idx) < SLOT_N8);
        b_lane = (8'(r_idx) < BM_N8);
        s_val  = s_lane ? r_slots[s_i] : 8'd0;
        b_val  = b_lane ? r_bitmap[b_i] : 8'd0;
        s_hit  = s_lane && (s_val == r_code);
        s_post = s_val;
        b_post = b_val;
        wrote  = 1'b0;

        if (r_act == ACT_CLEAR) begin
            last_idx = LAST_ALL;
        end else if (r_mode) begin
            last_idx = LAST_BM;
        end else begin
            last_idx = LAST_SL;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state    = ST_SCAN;
                    n_idx      = '0;
                    n_act      = i_item.action;
                    n_code     = i_item.key_code;
                    n_found    = 1'b0;
                    n_freed    = 1'b0;
                    n_free_vld = 1'b0;
                    n_free_idx = '0;
                    n_any      = 1'b0;
                    n_pres_bm  = 1'b0;
                end
            end

            ST_SCAN: begin
                // slot lane
                if (r_act == ACT_CLEAR) begin
                    s_post  = 8'd0;
                    slot_we = s_lane;
                end else if (!r_mode && c_key) begin
                    if (r_act == ACT_DEL) begin
                        if (s_hit && !r_freed) begin
                            s_post  = 8'd0;
                            slot_we = 1'b1;
                            n_freed = 1'b1;
                        end else if (s_hit) begin
                            n_found = 1'b1;
                        end
                    end else begin
                        if (s_hit) begin
                            n_found = 1'b1;
                        end
                        if (s_lane && s_val == 8'd0 && !r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free_idx = s_i;
                        end
                    end
                end
                slot_wdata = s_post;

                // bitmap lane: outside a clear, only the byte that holds the code is touched
                if (r_act == ACT_CLEAR) begin
                    b_post = 8'd0;
                    bm_we  = b_lane;
                end else if (r_mode && c_key && c_in_bm && b_lane
                             && (8'(r_idx) == {3'b000, c_byte})) begin
                    if (r_act == ACT_ADD) begin
                        b_post = b_val | (8'd1 << c_bit);
                        bm_we  = 1'b1;
                    end else if (r_act == ACT_DEL) begin
                        b_post = b_val & ~(8'd1 << c_bit);
                        bm_we  = 1'b1;
                    end
                    n_pres_bm = b_post[c_bit];
                end
                bm_wdata = b_post;

                n_any = r_any | (r_mode ? (b_post != 8'd0) : (s_post != 8'd0));

                n_idx = r_idx + SCAN_W'(1);
                if (r_idx == last_idx) begin
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // modifier bit n is code E0+n; E0 has zero low bits
                if (r_act == ACT_CLEAR) begin
                    n_mod = 8'd0;
                end else if (c_mod && r_act == ACT_ADD) begin
                    n_mod = r_mod | (8'd1 << r_code[2:0]);
                end else if (c_mod && r_act == ACT_DEL) begin
                    n_mod = r_mod & ~(8'd1 << r_code[2:0]);
                end

                // slot mode add takes the first empty slot found during the scan
                if (!r_mode && c_key && r_act == ACT_ADD && !r_found && r_free_vld) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_free_idx;
                    slot_wdata = r_code;
                    wrote      = 1'b1;
                end

                n_result.modifier_bits = n_mod;
                n_result.dropped       = 1'b0;
                n_result.key_present   = 1'b0;
                if (r_act == ACT_CLEAR) begin
                    n_result.any_key = 1'b0;
                end else begin
                    n_result.any_key = (n_mod != 8'd0) || r_any || wrote;
                    if (c_mod) begin
                        n_result.key_present = n_mod[r_code[2:0]];
                    end else if (c_key && r_mode) begin
                        n_result.key_present = r_pres_bm;
                        n_result.dropped     = !c_in_bm && (r_act != ACT_QUERY);
                    end else if (c_key) begin
                        n_result.key_present = r_found || wrote;
                        n_result.dropped     = (r_act == ACT_ADD) && !r_found && !r_free_vld;
                    end
                end

                n_done  = 1'b1;
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= 1'b1;
            r_mod   <= 8'd0;
            r_done  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slots[i] <= 8'd0;
            end
            for (int i = 0; i < BITMAP_BYTES; i++) begin
                r_bitmap[i] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            r_mod   <= n_mod;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (slot_we) begin
                r_slots[slot_waddr] <= slot_wdata;
            end
            if (bm_we) begin
                r_bitmap[bm_waddr] <= bm_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_act      <= n_act;
        r_code     <= n_code;
        r_found    <= n_found;
        r_freed    <= n_freed;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_any      <= n_any;
        r_pres_bm  <= n_pres_bm;
        r_result   <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ src/hkrb_checker.sv @@
// Port-level checks for hid_key_report_builder_unit, bound into that module.
// Depends on hkrb_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module hkrb_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             start,
    input wire             busy,
    input wire             o_done,
    input hkrb_pkg::t_out  o_result
);

    import hkrb_pkg::*;

    // accepted beat keeps the block busy while the stores are walked
    `HKRB_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // result beats are single strobes, never back to back
    `HKRB_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    // the result beat comes exactly when the block goes idle
    `HKRB_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, $fell(busy), o_done && !busy)
    // a dropped request never leaves its key held
    `HKRB_ASSERT_IMP(a_drop_absent, i_clk, i_rst_n, o_done && o_result.dropped,
        !o_result.key_present)
    // a held key means the report is not empty
    `HKRB_ASSERT_IMP(a_present_any, i_clk, i_rst_n, o_done && o_result.key_present,
        o_result.any_key)

endmodule

bind hid_key_report_builder_unit hkrb_checker u_hkrb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

@@ verif/hid_key_report_builder_unit_tb.sv @@
// Self-checking testbench for hid_key_report_builder_unit: key add/delete/query/clear
// requests in slot and bitmap modes, every report beat checked against an in-bench predictor.
// Depends on hkrb_pkg and the unit under test; nothing else.

module hid_key_report_builder_unit_tb;

    import hkrb_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int BYTES = BITMAP_BYTES_DEF;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS = 240;

    // ---------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ---------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    t_in  req_item = '0;
    logic busy;
    logic o_done;
    t_out o_result;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    hid_key_report_builder_unit #(
        .SLOT_COUNT  (SLOTS),
        .BITMAP_BYTES(BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (req_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the report and the mode bit.
    // Reset values match the block: everything empty, bitmap mode.
    // ---------------------------------------------------------------
    logic [7:0] slot_codes [SLOTS];
    logic [7:0] bitmap_bytes [BYTES];
    logic [7:0] mod_byte = '0;
    logic       bitmap_sel = 1'b1;

    t_in  pending_requests [$];   // requests not yet taken by the block
    t_out expected_reports [$];   // one predicted report per accepted beat

    int error_count = 0;
    int beats_sent = 0;
    int reports_seen = 0;
    int drops_seen = 0;
    int n_add = 0, n_del = 0, n_query = 0, n_clear = 0;
    int mode_writes = 0;

    initial begin
        foreach (slot_codes[i]) slot_codes[i] = '0;
        foreach (bitmap_bytes[i]) bitmap_bytes[i] = '0;
    end

    // Applies one request to the predicted report and returns the beat the
    // block should send back. Modifiers win over both stores; code zero is
    // never a key; outside a clear, only the store of the current mode is touched or looked at.
    function automatic t_out apply_request(t_in req);
        t_out       rpt;
        logic [7:0] code;
        logic       is_mod;
        logic       in_map;
        logic       adding;
        logic       held;
        logic       done_flag;
        logic [2:0] mbit;
        rpt = '0;
        code = req.key_code;
        is_mod = (code >= MOD_FIRST) && (code <= MOD_LAST);
        in_map = (int'(code >> BYTE_SHIFT) < BYTES);
        adding = (req.action == ACT_ADD);
        mbit = 3'(code - MOD_FIRST);
        if (req.action == ACT_CLEAR) begin
            foreach (slot_codes[i]) slot_codes[i] = '0;
            foreach (bitmap_bytes[i]) bitmap_bytes[i] = '0;
            mod_byte = '0;
        end else begin
            if (code != 8'd0 && req.action != ACT_QUERY) begin
                if (is_mod) begin
                    mod_byte[mbit] = adding;
                end else if (bitmap_sel) begin
                    if (!in_map)
                        rpt.dropped = 1'b1;
                    else
                        bitmap_bytes[code >> BYTE_SHIFT][code[2:0] & BIT_MASK] = adding;
                end else if (adding) begin
                    // a key already in a slot is not stored twice
                    held = 1'b0;
                    foreach (slot_codes[i]) if (slot_codes[i] == code) held = 1'b1;
                    done_flag = held;
                    foreach (slot_codes[i]) begin
                        if (!done_flag && slot_codes[i] == 8'd0) begin
                            slot_codes[i] = code;
                            done_flag = 1'b1;
                        end
                    end
                    rpt.dropped = !done_flag;
                end else begin
                    // free the first matching slot only
                    done_flag = 1'b0;
                    foreach (slot_codes[i]) begin
                        if (!done_flag && slot_codes[i] == code) begin
                            slot_codes[i] = '0;
                            done_flag = 1'b1;
                        end
                    end
                end
            end
            if (code == 8'd0)
                rpt.key_present = 1'b0;
            else if (is_mod)
                rpt.key_present = mod_byte[mbit];
            else if (bitmap_sel)
                rpt.key_present = in_map &&
                    bitmap_bytes[code >> BYTE_SHIFT][code[2:0] & BIT_MASK];
            else begin
                rpt.key_present = 1'b0;
                foreach (slot_codes[i]) if (slot_codes[i] == code) rpt.key_present = 1'b1;
            end
        end
        rpt.any_key = (mod_byte != 8'd0);
        if (bitmap_sel)
            foreach (bitmap_bytes[i]) rpt.any_key |= (bitmap_bytes[i] != 8'd0);
        else
            foreach (slot_codes[i]) rpt.any_key |= (slot_codes[i] != 8'd0);
        rpt.modifier_bits = mod_byte;
        return rpt;
    endfunction

    task automatic flag_mismatch(string msg);
        error_count++;
        $display("MISMATCH at %0t (report %0d): %s", $realtime, reports_seen, msg);
    endtask

    // ---------------------------------------------------------------
    // Driver: feeds pending requests in bursts with random gaps. A beat
    // is taken at an edge where start is high and busy is low; start is
    // held until then. Now and then the driver holds off until every
    // outstanding report has come back (once for sure at beat 300).
    // ---------------------------------------------------------------
    int   burst_left = 1;
    int   gap_left = 0;
    logic drain_wait = 1'b0;

    always @(posedge i_clk) begin : drive_proc
        logic taken;
        logic nxt_start;
        t_in  nxt_item;
        taken = start && !busy;
        nxt_start = 1'b0;
        nxt_item = req_item;
        if (i_rst_n) begin
            if (taken) begin
                expected_reports.push_back(apply_request(req_item));
                case (req_item.action)
                    ACT_ADD:   n_add++;
                    ACT_DEL:   n_del++;
                    ACT_QUERY: n_query++;
                    default:   n_clear++;
                endcase
                void'(pending_requests.pop_front());
                beats_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    // short bursts mostly, some long runs with no gaps at all
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
                end
                if (beats_sent == 300 || $urandom_range(0, 249) == 0)
                    drain_wait = 1'b1;
            end
            if (start && !taken) begin
                nxt_start = 1'b1;              // keep the beat up until taken
            end else if (drain_wait) begin
                if (expected_reports.size() == 0)
                    drain_wait = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                nxt_start = 1'b1;
                nxt_item = pending_requests[0];
            end
        end
        start <= nxt_start;
        req_item <= nxt_item;
    end

    // ---------------------------------------------------------------
    // Monitor: every strobed report beat is checked field by field
    // against the oldest prediction. The receiver has no back pressure.
    // ---------------------------------------------------------------
    t_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                flag_mismatch("report beat with no request outstanding");
            end else begin
                want = expected_reports.pop_front();
                if (o_result.key_present !== want.key_present)
                    flag_mismatch($sformatf("key_present got %b want %b",
                                            o_result.key_present, want.key_present));
                if (o_result.any_key !== want.any_key)
                    flag_mismatch($sformatf("any_key got %b want %b",
                                            o_result.any_key, want.any_key));
                if (o_result.modifier_bits !== want.modifier_bits)
                    flag_mismatch($sformatf("modifier_bits got %h want %h",
                                            o_result.modifier_bits, want.modifier_bits));
                if (o_result.dropped !== want.dropped)
                    flag_mismatch($sformatf("dropped got %b want %b",
                                            o_result.dropped, want.dropped));
                if (want.dropped)
                    drops_seen++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer helpers
    // ---------------------------------------------------------------
    task automatic push_req(t_action act, logic [7:0] code);
        t_in r;
        r.action = act;
        r.key_code = code;
        pending_requests.push_back(r);
    endtask

    // Block idle: nothing queued, nothing in flight, with slack on top so
    // the store walk has surely finished.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_reports.size() != 0 ||
               start || busy)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mode register write; only ever called with the block idle.
    task automatic write_mode(logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bitmap_sel = val;
        mode_writes++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stim_proc
        logic    phase_modes [RANDOM_PHASES];
        int      r;
        t_action act;
        logic [7:0] code;
        phase_modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bitmap mode corners: code zero, last in-map code, codes beyond
        // the map, both ends of the modifier range, clear with junk code.
        write_mode(1'b1);
        push_req(ACT_ADD, 8'h00);
        push_req(ACT_QUERY, 8'h00);
        push_req(ACT_ADD, 8'h04);
        push_req(ACT_ADD, 8'h7F);
        push_req(ACT_ADD, 8'h80);
        push_req(ACT_DEL, 8'hFF);
        push_req(ACT_QUERY, 8'h80);
        push_req(ACT_ADD, 8'hE0);
        push_req(ACT_ADD, 8'hE7);
        push_req(ACT_DEL, 8'hE0);
        push_req(ACT_DEL, 8'h04);
        push_req(ACT_CLEAR, 8'hAA);
        wait_idle();

        // Slot mode corners: fill all slots, repeat add, add when full,
        // delete of an absent key, free a slot and reuse it with code FF.
        write_mode(1'b0);
        for (int k = 0; k < SLOTS; k++)
            push_req(ACT_ADD, 8'(8'h04 + k));
        push_req(ACT_ADD, 8'h05);
        push_req(ACT_ADD, 8'h0A);
        push_req(ACT_DEL, 8'h0B);
        push_req(ACT_DEL, 8'h06);
        push_req(ACT_ADD, 8'hFF);
        push_req(ACT_QUERY, 8'h06);
        push_req(ACT_CLEAR, 8'h00);
        wait_idle();

        // Random phases, mode flipped (and sometimes rewritten unchanged)
        // between them; stores are not cleared, so contents carry across.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_mode(phase_modes[p]);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 40)      act = ACT_ADD;
                else if (r < 70) act = ACT_DEL;
                else if (r < 95) act = ACT_QUERY;
                else             act = ACT_CLEAR;
                // a small key pool keeps slots filling up and keys repeating
                r = $urandom_range(0, 99);
                if (r < 50)      code = 8'($urandom_range(4, 15));
                else if (r < 65) code = 8'(MOD_FIRST + $urandom_range(0, 7));
                else if (r < 70) code = 8'h00;
                else if (r < 80) code = 8'($urandom_range(8'h78, 8'h87));
                else             code = 8'($urandom_range(0, 255));
                push_req(act, code);
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        foreach (expected_reports[i])
            flag_mismatch("report never arrived");

        $display("Ran %0d requests (%0d add, %0d delete, %0d query, %0d clear), %0d reports",
                 beats_sent, n_add, n_del, n_query, n_clear, reports_seen);
        $display("over %0d mode writes; %0d reports carried a drop", mode_writes, drops_seen);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 2000 beats.
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
